/* hw/rtl/fifo_queue_with_keyed_removal_defines.svh */
// Assertion macros used by the keyed-removal queue datapath.
`ifndef FIFO_QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH
`define FIFO_QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH

`ifndef SYNTHESIS
`define FQKR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue assertion failed");
`define FQKR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue assertion failed");
`else
`define FQKR_ASSERT_SAME(lbl, ante, cons)
`define FQKR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/fqkr_pkg.sv */
// Shared constants, codes and command types for the keyed-removal queue.
package fqkr_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 16;
  localparam int ACT_W = 3;
  localparam int ST_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ  = 3'd0,
    ACT_DEQ  = 3'd1,
    ACT_PEEK = 3'd2,
    ACT_FIND = 3'd3,
    ACT_REM  = 3'd4
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

/* hw/rtl/fqkr_ctrl.sv */
// Request sequencer: captures a request, then runs it and strobes the result.
module fqkr_ctrl
  import fqkr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign cmd.load  = start && !busy_r;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

/* hw/rtl/fqkr_datapath.sv */
// Queue storage with parallel key compare, gap-closing shift and result registers.
`include "fifo_queue_with_keyed_removal_defines.svh"
module fqkr_datapath
  import fqkr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [ACT_W-1:0] in_action,
  input  logic [ID_W-1:0]  in_process_id,
  output logic [ST_W-1:0]  out_status,
  output logic [ID_W-1:0]  out_result_id,
  output logic [CNT_W-1:0] out_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [ACT_W-1:0] act_r;
  logic [ID_W-1:0]  key_r;
  logic [ID_W-1:0]  ids_r [DEPTH];
  logic [ID_W-1:0]  ids_nxt [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  status_t          status_nxt;
  logic [ID_W-1:0]  rid_nxt;
  logic [ST_W-1:0]  res_status_r;
  logic [ID_W-1:0]  res_id_r;
  logic [CNT_W-1:0] res_count_r;

  logic [DEPTH-1:0] hit;
  logic             found;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] shift_pos;
  logic             shift_en;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < count_r) && (ids_r[i] == key_r);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        pos   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_MISS;
    rid_nxt    = '0;
    shift_en   = 1'b0;
    shift_pos  = '0;
    case (action_t'(act_r))
      ACT_ENQ: begin
        if (count_r >= FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          count_nxt  = count_r + 1'b1;
        end
      end
      ACT_DEQ: begin
        if (count_r != '0) begin
          status_nxt = ST_OK;
          rid_nxt    = ids_r[0];
          shift_en   = 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      ACT_PEEK: begin
        if (count_r != '0) begin
          status_nxt = ST_OK;
          rid_nxt    = ids_r[0];
        end
      end
      ACT_FIND: begin
        if (found) begin
          status_nxt = ST_OK;
          rid_nxt    = key_r;
        end
      end
      ACT_REM: begin
        if (found) begin
          status_nxt = ST_OK;
          rid_nxt    = key_r;
          shift_en   = 1'b1;
          shift_pos  = pos;
          count_nxt  = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_MISS;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ids_nxt[i] = ids_r[i];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (shift_en && (IDX_W'(i) >= shift_pos)) begin
        ids_nxt[i] = ids_r[i + 1];
      end
    end
    if ((action_t'(act_r) == ACT_ENQ) && (count_r < FULL_CNT)) begin
      ids_nxt[count_r[IDX_W-1:0]] = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      key_r <= in_process_id;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        ids_r[i] <= ids_nxt[i];
      end
      res_status_r <= status_nxt;
      res_id_r     <= rid_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign out_status    = res_status_r;
  assign out_result_id = res_id_r;
  assign out_count     = res_count_r;

  `FQKR_ASSERT_SAME(a_count_bound, 1'b1, count_r <= FULL_CNT)
  `FQKR_ASSERT_NEXT(a_full_flag, cmd.exec && (status_nxt == ST_FULL), res_count_r == FULL_CNT)
  `FQKR_ASSERT_NEXT(a_miss_zero, cmd.exec && (status_nxt != ST_OK), res_id_r == '0)
  `FQKR_ASSERT_NEXT(a_idle_hold, !cmd.exec, count_r == $past(count_r))

endmodule

/* hw/rtl/fifo_queue_with_keyed_removal.sv */
// Top level of the ordered process-identifier queue with removal by key.
// A request is taken with start when busy is low, and the sequencer then
// runs it in its execute state against all queued entries
// at once (parallel key compare and a gap-closing shift), and the result
// appears on the out_ ports with out_valid high for exactly one cycle, in
// the cycle where busy has dropped again so the next request can be given.
// The receiver cannot stall: a result must be taken in the cycle it shows.
module fifo_queue_with_keyed_removal
  import fqkr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [ACT_W-1:0] in_action,
  input  logic [ID_W-1:0]  in_process_id,
  output logic             out_valid,
  output logic [ST_W-1:0]  out_status,
  output logic [ID_W-1:0]  out_result_id,
  output logic [CNT_W-1:0] out_count
);

  dp_cmd_t cmd;

  fqkr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fqkr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_process_id (in_process_id),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .out_count     (out_count)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the keyed-removal queue: a directed table, then random requests.
module tb_top;
  import fqkr_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 125;
  localparam int POOL_SIZE      = 20;
  localparam int ROWS           = 23;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } queue_reply_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  pid;
    logic [4:0]       reps;
    logic             typed;
    queue_reply_t     reply;
  } table_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [ACT_W-1:0] in_action;
  logic [ID_W-1:0]  in_process_id;
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [ID_W-1:0]  out_result_id;
  logic [CNT_W-1:0] out_count;

  logic             row_typed;
  queue_reply_t     row_reply;

  logic [ID_W-1:0]  held_ids[$];
  queue_reply_t     expected_replies[$];

  int unsigned cycle_count = 0;
  int          error_count = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          full_drops = 0;
  int          misses = 0;

  int enq_bias [PHASES] = '{70, 25, 50, 85, 15, 55, 65, 20, 45, 50};

  // Entry fill uses consecutive ids starting at the row's id.
  table_row_t directed_rows [ROWS] = '{
    '{ACT_DEQ,       16'h0000, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd0}},
    '{ACT_PEEK,      16'hFFFF, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd0}},
    '{ACT_FIND,      16'h0000, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd0}},
    '{ACT_REM,       16'hFFFF, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd0}},
    '{ACT_SPARE_HI,  16'hFFFF, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd0}},
    '{ACT_ENQ,       16'h0000, 5'd1,  1'b1, '{ST_OK,   16'h0000, 5'd1}},
    '{ACT_ENQ,       16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'h0000, 5'd2}},
    '{ACT_PEEK,      16'h0000, 5'd1,  1'b1, '{ST_OK,   16'h0000, 5'd2}},
    '{ACT_FIND,      16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'hFFFF, 5'd2}},
    '{ACT_ENQ,       16'h8000, 5'd14, 1'b0, '0},
    '{ACT_ENQ,       16'h5555, 5'd1,  1'b1, '{ST_FULL, 16'h0000, 5'd16}},
    '{ACT_REM,       16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'hFFFF, 5'd15}},
    '{ACT_REM,       16'h800D, 5'd1,  1'b0, '0},
    '{ACT_FIND,      16'hABCD, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd14}},
    '{ACT_REM,       16'hABCD, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd14}},
    '{ACT_SPARE_LO,  16'h0000, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd14}},
    '{ACT_SPARE_MID, 16'h8003, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 5'd14}},
    '{ACT_DEQ,       16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'h0000, 5'd13}},
    '{ACT_PEEK,      16'h0000, 5'd1,  1'b0, '0},
    '{ACT_ENQ,       16'h8003, 5'd1,  1'b0, '0},
    '{ACT_REM,       16'h8003, 5'd1,  1'b0, '0},
    '{ACT_FIND,      16'h8003, 5'd1,  1'b0, '0},
    '{ACT_REM,       16'h8000, 5'd1,  1'b0, '0}
  };

  fifo_queue_with_keyed_removal dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_process_id (in_process_id),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .out_count     (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             expected_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic queue_reply_t apply_queue_action(input logic [ACT_W-1:0] act,
                                                      input logic [ID_W-1:0] key);
    queue_reply_t r;
    int pos;
    r.status = ST_MISS;
    r.id = '0;
    pos = -1;
    case (act)
      ACT_ENQ: begin
        if (held_ids.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_ids.push_back(key);
          r.status = ST_OK;
        end
      end
      ACT_DEQ: begin
        if (held_ids.size() > 0) begin
          r.id = held_ids.pop_front();
          r.status = ST_OK;
        end
      end
      ACT_PEEK: begin
        if (held_ids.size() > 0) begin
          r.id = held_ids[0];
          r.status = ST_OK;
        end
      end
      ACT_FIND, ACT_REM: begin
        foreach (held_ids[i]) begin
          if (pos < 0 && held_ids[i] == key) pos = i;
        end
        if (pos >= 0) begin
          r.id = held_ids[pos];
          r.status = ST_OK;
          if (act == ACT_REM) held_ids.delete(pos);
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(held_ids.size());
    return r;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Results are checked before the request taken at the same edge is predicted.
  always @(posedge clk) begin
    queue_reply_t want;
    queue_reply_t predicted;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_replies.size() == 0) begin
          report_error($sformatf("unexpected result: status %0d id %h count %0d",
                                 out_status, out_result_id, out_count));
        end else begin
          want = expected_replies.pop_front();
          results_checked++;
          if (out_status !== want.status || out_result_id !== want.id ||
              out_count !== want.count) begin
            report_error($sformatf(
              "result %0d: expected status %0d id %h count %0d, got status %0d id %h count %0d",
              results_checked, want.status, want.id, want.count,
              out_status, out_result_id, out_count));
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        predicted = apply_queue_action(in_action, in_process_id);
        expected_replies.push_back(row_typed ? row_reply : predicted);
        requests_sent++;
        if (predicted.status == ST_FULL) full_drops++;
        if (predicted.status == ST_MISS) misses++;
      end
    end
  end

  task automatic issue(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] pid, input int gap,
                       input logic typed, input queue_reply_t reply);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_action     <= act;
    in_process_id <= pid;
    row_typed     <= typed;
    row_reply     <= reply;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int n;
    int k;
    int gap;
    bit idle_on;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  pid;
    logic [ID_W-1:0]  id_pool [POOL_SIZE];
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_action     <= ACT_ENQ;
    in_process_id <= '0;
    row_typed     <= 1'b0;
    row_reply     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < ROWS; n++) begin
      for (k = 0; k < directed_rows[n].reps; k++) begin
        issue(directed_rows[n].act, directed_rows[n].pid + ID_W'(k), 0,
              directed_rows[n].typed, directed_rows[n].reply);
      end
    end

    // A small pool of ids per phase keeps finds, removals and duplicates frequent.
    for (phase = 0; phase < PHASES; phase++) begin
      foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
      idle_on = (phase % 3 != 2) && (phase < PHASES - 1);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        k = $urandom_range(99);
        if (k < 4) begin
          act = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        end else if (k < 4 + enq_bias[phase]) begin
          act = ACT_ENQ;
        end else begin
          k = $urandom_range(9);
          act = (k < 3) ? ACT_REM : (k < 6) ? ACT_DEQ : (k < 8) ? ACT_FIND : ACT_PEEK;
        end
        pid = ($urandom_range(7) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(POOL_SIZE-1)];
        gap = (idle_on && $urandom_range(4) == 0) ? $urandom_range(17, 1) : 0;
        issue(act, pid, gap, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results in %0d cycles.",
             requests_sent, results_checked, cycle_count);
    $display("Outcomes included %0d enqueues dropped on a full queue and %0d empty or miss cases.",
             full_drops, misses);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fqkr_pkg.sv
hw/rtl/fqkr_ctrl.sv
hw/rtl/fqkr_datapath.sv
hw/rtl/fifo_queue_with_keyed_removal.sv
verif/tb_top.sv
